[sv/chs_pkg.sv]
// Package for the chained hash set: widths, commands, sequencer states.
// No dependencies.
package chs_pkg;
    localparam int BUCKETS_DEF    = 769;
    localparam int POOL_NODES_DEF = 1024;
    localparam int KEY_BITS_DEF   = 20;
    localparam int CMD_W = 2;
    localparam int KEY_W = 20;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MOD, S_HEAD, S_HEADW, S_READ, S_READW, S_CHECK,
        S_UPDATE, S_DONE
    } t_state;
endpackage

[sv/chs_if.sv]
// Valid/ready channel carrying a payload of parameterized type.
// Depends on nothing.
interface chs_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/chs_mod.sv]
// Shared modulo unit: key modulo bucket count by reciprocal multiply,
// back-multiply and one corrective subtract. Depends on chs_pkg.
module chs_mod #(
    parameter int KEY_BITS = chs_pkg::KEY_BITS_DEF,
    parameter int BUCKETS  = chs_pkg::BUCKETS_DEF,
    localparam int BW = $clog2(BUCKETS)
) (
    input  logic                i_clk,
    input  logic                i_start,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                o_done,
    output logic [BW-1:0]       o_rem
);
    import chs_pkg::*;
    localparam int RW = (KEY_BITS > BW) ? KEY_BITS : BW;
    localparam logic [RW:0] DIV = (RW + 1)'(BUCKETS);
    // floor(2^KEY_BITS / BUCKETS): the estimated quotient is low by at most one
    localparam logic [KEY_BITS:0] RECIP = (KEY_BITS + 1)'((64'd1 << KEY_BITS) / BUCKETS);
    logic [KEY_BITS-1:0]  r_k, r_q;
    logic [RW-1:0]        r_rem;
    logic [1:0]           r_cnt;
    logic [2*KEY_BITS:0]  w_prod;
    logic [KEY_BITS+RW:0] w_qd;
    assign w_prod = r_k * RECIP;
    assign w_qd   = r_q * DIV;
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k   <= i_key;
            r_cnt <= 2'd3;
        end else begin
            case (r_cnt)
                2'd3: r_q <= w_prod[2*KEY_BITS-1:KEY_BITS];
                2'd2: r_rem <= RW'(r_k) - w_qd[RW-1:0];
                // estimate is below twice the divisor
                2'd1: if ({1'b0, r_rem} >= DIV) r_rem <= RW'({1'b0, r_rem} - DIV);
                default: ;
            endcase
            if (r_cnt != 2'd0) r_cnt <= r_cnt - 2'd1;
        end
    end
    assign o_done = (r_cnt == 2'd0);
    assign o_rem  = r_rem[BW-1:0];
endmodule

[sv/chained_hash_set_top.sv]
// Top level of the chained hash set: sequencer, bucket/node/free memories.
// Depends on chs_pkg, chs_if, chs_mod.
// One item at a time: the accept cycle, the shared modulo unit, the bucket head
// read, then per chain node visited a registered node memory read and a
// compare; on a miss the chain end is seen in a further read state; then an
// update state and a result state that holds until the result is taken.
// After reset a clearing pass writes every bucket head empty; no item is
// accepted meanwhile. The free stack is a fill count over a memory;
// entries below the lowest count reached were never written and read as
// their own index.
module chained_hash_set_top #(
    parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF,
    parameter int KEY_BITS   = chs_pkg::KEY_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    chs_if.sink   i_in,
    chs_if.source o_out
);
    import chs_pkg::*;
    localparam int NW = $clog2(POOL_NODES + 1);
    localparam int NI = $clog2(POOL_NODES);
    localparam int BW = $clog2(BUCKETS);
    localparam logic [NW-1:0] NULLN = NW'(POOL_NODES);

    logic [NW-1:0]       m_head [BUCKETS];
    logic [KEY_BITS-1:0] m_key  [POOL_NODES];
    logic [NW-1:0]       m_link [POOL_NODES];
    logic [NI-1:0]       m_free [POOL_NODES];

    t_state r_st, n_st;
    logic [CMD_W-1:0]    r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [BW-1:0]       r_b, r_clr;
    logic [NW-1:0]       r_cur, r_prev, r_hd, r_fc, r_lw;
    logic [KEY_BITS-1:0] r_nk;
    logic [NW-1:0]       r_nl;
    logic [NI-1:0]       r_fd;
    logic                r_pres, r_stat, r_ov;
    logic [NW:0]         r_steps;
    logic                w_mdone;
    logic [BW-1:0]       w_rem;

    chs_mod #(.KEY_BITS(KEY_BITS), .BUCKETS(BUCKETS)) u_mod (
        .i_clk(i_clk), .i_start(r_st == S_IDLE && i_in.valid),
        .i_key(i_in.data.key[KEY_BITS-1:0]), .o_done(w_mdone), .o_rem(w_rem));

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_CLEAR:  if (r_clr == BW'(BUCKETS - 1)) n_st = S_IDLE;
            S_IDLE:   if (i_in.valid) n_st = S_MOD;
            S_MOD:    if (w_mdone) n_st = S_HEAD;
            S_HEAD:   n_st = S_HEADW;
            S_HEADW:  n_st = S_READ;
            S_READ:   n_st = (r_cur >= NULLN || r_steps >= (NW+1)'(POOL_NODES))
                             ? S_UPDATE : S_READW;
            S_READW:  n_st = S_CHECK;
            S_CHECK:  n_st = (r_nk == r_key) ? S_UPDATE : S_READ;
            S_UPDATE: n_st = S_DONE;
            S_DONE:   if (o_out.ready) n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready        = (r_st == S_IDLE);
        o_out.valid       = (r_st == S_DONE);
        o_out.data.was_present = r_pres;
        o_out.data.status      = r_stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLEAR;
            r_clr <= '0;
            r_fc  <= NULLN;
            r_lw  <= NULLN;
        end else begin
            r_st <= n_st;
            if (r_st == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_st == S_UPDATE) begin
                if (r_cmd == CMD_ADD && !r_pres && r_fc != '0) begin
                    r_fc <= r_fc - 1'b1;
                    if (r_fc == r_lw) r_lw <= r_lw - 1'b1;
                end
                if (r_cmd == CMD_REMOVE && r_pres && r_fc < NULLN) r_fc <= r_fc + 1'b1;
            end
        end
    end

    // memories and datapath
    always_ff @(posedge i_clk) begin
        r_hd <= m_head[r_b];
        r_nk <= m_key[r_cur[NI-1:0]];
        r_nl <= m_link[r_cur[NI-1:0]];
        r_fd <= m_free[r_fc[NI-1:0] - 1'b1];
        r_ov <= (r_fc != r_lw);
        if (r_st == S_CLEAR) m_head[r_clr] <= NULLN;
        case (r_st)
            S_IDLE: begin
                r_cmd <= i_in.data.command;
                r_key <= i_in.data.key[KEY_BITS-1:0];
            end
            S_MOD: begin
                r_b <= w_rem;
                r_pres <= 1'b0;
                r_stat <= 1'b0;
                r_prev <= NULLN;
                r_steps <= '0;
            end
            S_HEADW: r_cur <= r_hd;
            S_READ:  r_steps <= r_steps + 1'b1;
            S_CHECK: begin
                if (r_nk == r_key) r_pres <= 1'b1;
                else begin
                    r_prev <= r_cur;
                    r_cur  <= r_nl;
                end
            end
            S_UPDATE: begin
                if (r_cmd == CMD_ADD && !r_pres) begin
                    if (r_fc == '0) r_stat <= 1'b1;
                    else begin
                        logic [NI-1:0] w_n;
                        w_n = r_ov ? r_fd : NI'(r_fc - 1'b1);
                        m_key[w_n]  <= r_key;
                        m_link[w_n] <= r_hd;
                        m_head[r_b] <= NW'(w_n);
                    end
                end
                if (r_cmd == CMD_REMOVE && r_pres) begin
                    if (r_prev < NULLN) m_link[r_prev[NI-1:0]] <= r_nl;
                    else m_head[r_b] <= r_nl;
                    if (r_fc < NULLN) m_free[r_fc[NI-1:0]] <= r_cur[NI-1:0];
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !i_in.ready) else $error("ready while busy");
    a_fc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= NULLN) else $error("free count overflow");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.status |-> !o_out.data.was_present)
        else $error("full with key present");
`endif
endmodule

[verif/chs_tb_pkg.sv]
// Item layouts of the hash set channels as seen by the testbench.
// Depends on chs_pkg.
`timescale 1ns / 100ps
package chs_tb_pkg;
    import chs_pkg::*;

    // command code with no operation of its own; the block treats it as a query
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic was_present;
        logic status;
    } t_rsp;
endpackage

[verif/chs_checker.sv]
// Set-membership predictor and result scoreboard for the chained hash set.
// Depends on chs_pkg, chs_tb_pkg, chs_if.
`timescale 1ns / 100ps
module chs_checker #(
    parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    chs_if       i_in,
    chs_if       i_out,
    output int   o_errors,
    output int   o_pending
);
    import chs_pkg::*;
    import chs_tb_pkg::*;

    int unsigned head_of[BUCKETS];
    int unsigned key_of[POOL_NODES];
    int unsigned next_of[POOL_NODES];
    int unsigned spare_nodes[POOL_NODES];
    int unsigned n_spare;
    t_rsp        awaited[$];

    initial begin
        for (int i = 0; i < BUCKETS; i++) head_of[i] = POOL_NODES;
        for (int i = 0; i < POOL_NODES; i++) begin
            spare_nodes[i] = i;
            key_of[i]      = 0;
            next_of[i]     = 0;
        end
        n_spare  = POOL_NODES;
        o_errors = 0;
    end

    function automatic t_rsp apply_op(t_req r);
        int unsigned b, cur, prv, hit, steps;
        t_rsp res;
        b   = r.key % BUCKETS;
        cur = head_of[b];
        prv = POOL_NODES;
        hit = POOL_NODES;
        res = '0;
        for (steps = 0; steps < POOL_NODES && cur < POOL_NODES; steps++) begin
            if (key_of[cur] == r.key) begin
                hit = cur;
                break;
            end
            prv = cur;
            cur = next_of[cur];
        end
        res.was_present = (hit < POOL_NODES);
        if (r.command == CMD_ADD && !res.was_present) begin
            if (n_spare == 0) begin
                res.status = 1'b1;
            end else begin
                n_spare--;
                cur          = spare_nodes[n_spare];
                key_of[cur]  = r.key;
                next_of[cur] = head_of[b];
                head_of[b]   = cur;
            end
        end else if (r.command == CMD_REMOVE && res.was_present) begin
            if (prv < POOL_NODES) next_of[prv] = next_of[hit];
            else                  head_of[b]   = next_of[hit];
            spare_nodes[n_spare] = hit;
            n_spare++;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want, got;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) awaited.push_back(apply_op(i_in.data));
            if (i_out.valid && i_out.ready) begin
                got = i_out.data;
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected result was_present=%0b status=%0b",
                             $time, got.was_present, got.status);
                    o_errors++;
                end else begin
                    want = awaited.pop_front();
                    if (got.was_present !== want.was_present) begin
                        $display("%0t: was_present expected %0b actual %0b",
                                 $time, want.was_present, got.was_present);
                        o_errors++;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0b actual %0b",
                                 $time, want.status, got.status);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = awaited.size();
    end
endmodule

[verif/tb.sv]
// Testbench top for chained_hash_set_top: drives add/remove/query items, stalls
// both sides at random and reports the verdict. Depends on chs_pkg, chs_tb_pkg,
// chs_if, chs_checker and the block.
`timescale 1ns / 100ps
module tb;
    import chs_pkg::*;
    import chs_tb_pkg::*;

    localparam int LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   idle_on = 1'b1;
    bit   long_hold = 1'b0;
    int   n_errors, n_pending, cycles;

    chs_if #(.T(t_req)) req_ch ();
    chs_if #(.T(t_rsp)) rsp_ch ();

    chained_hash_set_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (rsp_ch)
    );

    chs_checker u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (req_ch),
        .i_out    (rsp_ch),
        .o_errors (n_errors),
        .o_pending(n_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            if (long_hold) begin
                rsp_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
        t_req r;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        r.command = cmd;
        r.key     = key;
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (n_pending != 0);
        repeat (60) @(posedge i_clk);
    endtask

    // mostly keys that pile up in a few buckets, sometimes any 20-bit key
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 5) == 0) return KEY_W'($urandom);
        return KEY_W'($urandom_range(0, 7) + 769 * $urandom_range(0, 5));
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd();
        int w;
        w = $urandom_range(0, 19);
        if (w < 8)  return CMD_ADD;
        if (w < 14) return CMD_REMOVE;
        if (w < 19) return CMD_QUERY;
        return CMD_SPARE;
    endfunction

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty set, duplicates, shared bucket, unlink head/tail, edges
        send_item(CMD_QUERY, 20'd0);
        send_item(CMD_ADD, 20'd0);
        send_item(CMD_ADD, 20'd0);
        send_item(CMD_ADD, 20'd769);
        send_item(CMD_ADD, 20'd1538);
        send_item(CMD_QUERY, 20'd769);
        send_item(CMD_SPARE, 20'd1538);
        send_item(CMD_SPARE, 20'd5);
        send_item(CMD_REMOVE, 20'd0);
        send_item(CMD_REMOVE, 20'd0);
        send_item(CMD_REMOVE, 20'd1538);
        send_item(CMD_QUERY, 20'd769);
        send_item(CMD_ADD, 20'hFFFFF);
        send_item(CMD_QUERY, 20'hFFFFF);
        send_item(CMD_REMOVE, 20'hFFFFF);
        send_item(CMD_QUERY, 20'hFFFFF);
        send_item(CMD_ADD, 20'h55555);
        send_item(CMD_ADD, 20'hAAAAA);
        send_item(CMD_REMOVE, 20'd769);
        send_item(CMD_QUERY, 20'd768);

        for (int i = 0; i < 280; i++) begin
            if (i == 100) long_hold = 1'b1;
            send_item(pick_cmd(), pick_key());
        end
        drain();

        idle_on = 1'b0;
        for (int i = 0; i < 100; i++) send_item(pick_cmd(), pick_key());
        drain();

        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

[sim.f]
sv/chs_pkg.sv
sv/chs_if.sv
sv/chs_mod.sv
sv/chained_hash_set_top.sv
verif/chs_tb_pkg.sv
verif/chs_checker.sv
verif/tb.sv
